### src/rtcb_pkg.sv
`default_nettype none

package rtcb_pkg;

    // Sequence phases
    typedef logic [3:0] t_phase;

    localparam t_phase PH_IDLE   = 4'd0;
    localparam t_phase PH_RCMD   = 4'd1;
    localparam t_phase PH_RDATA  = 4'd2;
    localparam t_phase PH_WCLR   = 4'd3;
    localparam t_phase PH_WSEP   = 4'd4;
    localparam t_phase PH_WBURST = 4'd5;
    localparam t_phase PH_WGAP   = 4'd6;
    localparam t_phase PH_WSET   = 4'd7;

    // Request kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Link commands and register values
    localparam logic [7:0] CMD_BURST_READ  = 8'hBF;
    localparam logic [7:0] CMD_BURST_WRITE = 8'hBE;
    localparam logic [7:0] ADDR_WP         = 8'h8E;
    localparam logic [7:0] WP_CLEAR        = 8'h00;
    localparam logic [7:0] WP_SET          = 8'h80;

    // Burst length in bytes (1..8) and gap length in slots (1..4095)
    localparam logic [3:0]  BURST_BYTES = 4'd8;
    localparam logic [11:0] GAP_TICKS   = 12'd16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] write_data;
        logic        data_pin_in;
    } t_req;

    typedef struct packed {
        logic        chip_enable;
        logic        clock_pulse;
        logic        data_out;
        logic        data_drive;
        logic        busy_res;
        logic        read_valid;
        logic [63:0] read_data;
    } t_res;

endpackage

`default_nettype wire

### src/rtcb_in_if.sv
`default_nettype none

interface rtcb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] write_data;
    logic        data_pin_in;

    modport source (output valid, kind, write_data, data_pin_in, input ready);
    modport sink   (input valid, kind, write_data, data_pin_in, output ready);
endinterface

`default_nettype wire

### src/rtcb_out_if.sv
`default_nettype none

interface rtcb_out_if;
    logic        valid;
    logic        ready;
    logic        chip_enable;
    logic        clock_pulse;
    logic        data_out;
    logic        data_drive;
    logic        busy_res;
    logic        read_valid;
    logic [63:0] read_data;

    modport source (output valid, chip_enable, clock_pulse, data_out, data_drive,
                    busy_res, read_valid, read_data, input ready);
    modport sink   (input valid, chip_enable, clock_pulse, data_out, data_drive,
                    busy_res, read_valid, read_data, output ready);
endinterface

`default_nettype wire

### src/rtcb_seq.sv
`default_nettype none

module rtcb_seq
    import rtcb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_req i_req,
    output t_res      o_res
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bit, n_bit;
    logic [3:0]  r_byte, n_byte;
    logic [7:0]  r_shift, n_shift;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_wbuf, n_wbuf;
    logic [11:0] r_gap, n_gap;

    logic [2:0]  bit_inc;
    logic [3:0]  byte_inc;
    logic [3:0]  byte_dec;
    logic [7:0]  rd_shift;
    logic [11:0] gap_inc;
    logic [3:0]  byte_cnt;
    logic [7:0]  next_byte;

    assign bit_inc  = r_bit + 3'd1;
    assign byte_inc = r_byte + 4'd1;
    assign byte_dec = byte_inc - 4'd1;
    assign rd_shift = {i_req.data_pin_in, r_shift[7:1]};
    assign gap_inc  = r_gap + 12'd1;

    always_comb begin
        case (r_phase)
            PH_RCMD:   byte_cnt = 4'd1;
            PH_WBURST: byte_cnt = BURST_BYTES + 4'd1;
            default:   byte_cnt = 4'd2;
        endcase
    end

    // Byte to load after the current one has gone out
    always_comb begin
        case (r_phase)
            PH_RCMD: next_byte = CMD_BURST_READ;
            PH_WCLR: next_byte = (byte_inc == 4'd0) ? ADDR_WP : WP_CLEAR;
            PH_WSET: next_byte = (byte_inc == 4'd0) ? ADDR_WP : WP_SET;
            default: begin
                if (byte_inc == 4'd0) begin
                    next_byte = CMD_BURST_WRITE;
                end else begin
                    next_byte = r_wbuf[{byte_dec[2:0], 3'b000} +: 8];
                end
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_acc   = r_acc;
        n_wbuf  = r_wbuf;
        n_gap   = r_gap;
        o_res   = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_req.kind == KIND_READ || i_req.kind == KIND_WRITE) begin
                    o_res.data_drive = 1'b1;
                    n_bit  = 3'd0;
                    n_byte = 4'd0;
                    n_gap  = 12'd0;
                    if (i_req.kind == KIND_READ) begin
                        n_acc   = '0;
                        n_phase = PH_RCMD;
                        n_shift = CMD_BURST_READ;
                    end else begin
                        n_wbuf  = i_req.write_data;
                        n_phase = PH_WCLR;
                        n_shift = ADDR_WP;
                    end
                end
            end
            PH_RDATA: begin
                o_res.chip_enable = 1'b1;
                o_res.clock_pulse = 1'b1;
                n_shift = rd_shift;
                n_bit   = bit_inc;
                if (r_bit == 3'd7) begin
                    for (int i = 0; i < 8; i++) begin
                        if (r_byte[2:0] == 3'(i)) begin
                            n_acc[i*8 +: 8] = r_acc[i*8 +: 8] | rd_shift;
                        end
                    end
                    n_shift = 8'd0;
                    n_byte  = byte_inc;
                    if (byte_inc >= BURST_BYTES) begin
                        o_res.read_valid = 1'b1;
                        o_res.read_data  = n_acc;
                        n_byte  = 4'd0;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_WSEP: begin
                o_res.data_drive = 1'b1;
                n_phase = PH_WBURST;
                n_byte  = 4'd0;
                n_bit   = 3'd0;
                n_shift = CMD_BURST_WRITE;
            end
            PH_WGAP: begin
                o_res.data_drive = 1'b1;
                n_gap = gap_inc;
                if (gap_inc >= GAP_TICKS || gap_inc == 12'd0) begin
                    n_gap   = 12'd0;
                    n_phase = PH_WSET;
                    n_byte  = 4'd0;
                    n_bit   = 3'd0;
                    n_shift = ADDR_WP;
                end
            end
            PH_RCMD, PH_WCLR, PH_WBURST, PH_WSET: begin
                o_res.chip_enable = 1'b1;
                o_res.clock_pulse = 1'b1;
                o_res.data_drive  = 1'b1;
                o_res.data_out    = r_shift[0];
                n_shift = {1'b0, r_shift[7:1]};
                n_bit   = bit_inc;
                if (r_bit == 3'd7) begin
                    n_byte = byte_inc;
                    if (byte_inc >= byte_cnt) begin
                        n_byte  = 4'd0;
                        n_shift = 8'd0;
                        case (r_phase)
                            PH_RCMD:   n_phase = PH_RDATA;
                            PH_WCLR:   n_phase = PH_WSEP;
                            PH_WBURST: begin
                                n_phase = PH_WGAP;
                                n_gap   = 12'd0;
                            end
                            default:   n_phase = PH_IDLE;
                        endcase
                    end else begin
                        n_shift = next_byte;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        o_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= '0;
            r_acc   <= '0;
            r_wbuf  <= '0;
            r_gap   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_acc   <= n_acc;
            r_wbuf  <= n_wbuf;
            r_gap   <= n_gap;
        end
    end

endmodule

`default_nettype wire

### src/rtcb_obuf.sv
`default_nettype none

module rtcb_obuf
    import rtcb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  wire t_res i_res,
    input  wire logic i_ready,
    output logic      o_valid,
    output t_res      o_res
);

    logic r_valid;
    t_res r_res;

    // Held until taken; reloaded in the same cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

### src/rtc_three_wire_burst_master.sv
`default_nettype none

// Bit-slot master for a three-wire real-time-clock link (chip enable, serial
// clock, bidirectional data). Every request gives exactly one result: the pin
// levels for one bit slot. Kind 1 starts a burst read (command 0xBF, then
// BURST_BYTES bytes sampled, returned with read_valid in the last slot); kind 2
// starts a burst write (write protect cleared, 0xBE plus every buffered byte,
// GAP_TICKS gap slots, write protect set again). Starts while busy, and kind 3,
// count as plain ticks. The sequencer state is updated in the cycle of
// acceptance and the result sits in one output register, so a new request is
// taken every cycle while results are drained.
module rtc_three_wire_burst_master
    import rtcb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rtcb_in_if.sink     i_req,
    rtcb_out_if.source  o_res
);

    logic fire;
    t_req req;
    t_res seq_res;
    t_res buf_res;
    logic buf_valid;

    assign i_req.ready = !buf_valid || o_res.ready;
    assign fire        = i_req.valid && i_req.ready;

    assign req.kind        = i_req.kind;
    assign req.write_data  = i_req.write_data;
    assign req.data_pin_in = i_req.data_pin_in;

    rtcb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (req),
        .o_res   (seq_res)
    );

    rtcb_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (seq_res),
        .i_ready (o_res.ready),
        .o_valid (buf_valid),
        .o_res   (buf_res)
    );

    assign o_res.valid       = buf_valid;
    assign o_res.chip_enable = buf_res.chip_enable;
    assign o_res.clock_pulse = buf_res.clock_pulse;
    assign o_res.data_out    = buf_res.data_out;
    assign o_res.data_drive  = buf_res.data_drive;
    assign o_res.busy_res    = buf_res.busy_res;
    assign o_res.read_valid  = buf_res.read_valid;
    assign o_res.read_data   = buf_res.read_data;

`ifndef NO_ASSERTIONS
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_res.valid)
        else $error("accepted request did not produce a result");

    a_read_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.read_valid |-> !o_res.busy_res)
        else $error("read completion while still busy");

    a_data_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.read_valid |-> o_res.read_data == 64'd0)
        else $error("read data present without completion");

    a_clock_needs_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.clock_pulse |-> o_res.chip_enable)
        else $error("clock pulse with chip enable low");
`endif

endmodule

`default_nettype wire
